### design/mfmsb_pkg.sv
// shared types, codes and constant-function helpers for the mono fold meter
// and band spectrum block; no dependencies
`timescale 1ns / 1ps

package mfmsb_pkg;

  localparam int DEF_WINDOW_SIZE = 512;
  localparam int DEF_BAND_COUNT  = 16;

  // input kinds
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_STATS = 2'd1;
  localparam logic [1:0] KIND_SPEC  = 2'd2;

  // result types
  localparam logic [1:0] RES_FRAME = 2'd0;
  localparam logic [1:0] RES_STATS = 2'd1;
  localparam logic [1:0] RES_BAND  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_STEREO  = 2'd1;
  localparam logic [1:0] REG_DOWNMIX = 2'd2;

  localparam logic [63:0] FULL_Q30    = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] RATIO_Q30   = 64'd909703494;
  localparam logic [63:0] SQRT2_Q16   = 64'd92682;
  localparam logic [6:0]  LVL_TOP     = 7'd100;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DRAIN,
    ST_BF_RD,
    ST_BF_LAT,
    ST_BF_MUL,
    ST_BF_WA,
    ST_BF_WB,
    ST_BN_INIT,
    ST_BN_RD,
    ST_BN_LAT,
    ST_BN_SQ,
    ST_BN_SRCH,
    ST_BN_OUT
  } st_t;

  typedef logic [56:0] thr_arr_t [101];

  // taylor term divisors (n+1)(n+2)
  function automatic logic [63:0] tdiv(input logic [63:0] v, input logic odd, input int it);
    case (it)
      1:       return odd ? v / 6   : v / 2;
      2:       return odd ? v / 20  : v / 12;
      3:       return odd ? v / 42  : v / 30;
      4:       return odd ? v / 72  : v / 56;
      5:       return odd ? v / 110 : v / 90;
      6:       return odd ? v / 156 : v / 132;
      7:       return odd ? v / 210 : v / 182;
      8:       return odd ? v / 272 : v / 240;
      default: return odd ? v / 342 : v / 306;
    endcase
  endfunction

  function automatic longint taylor_q30(input logic [63:0] x, input logic odd);
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    x2   = (x * x) >> 30;
    term = odd ? x : FULL_Q30;
    sum  = longint'(term);
    for (int it = 1; it <= 9; it++) begin
      term = tdiv((term * x2) >> 30, odd, it);
      if ((it & 1) == 1) sum = sum - longint'(term);
      else               sum = sum + longint'(term);
    end
    return sum;
  endfunction

  // cos of a 32-bit phase, q30
  function automatic longint cos_q30(input logic [31:0] ph);
    logic [63:0] x;
    x = ({32'd0, ph & 32'h3FFF_FFFF} * HALF_PI_Q30) >> 30;
    case (ph[31:30])
      2'd0:    return taylor_q30(x, 1'b0);
      2'd1:    return -taylor_q30(x, 1'b1);
      2'd2:    return -taylor_q30(x, 1'b0);
      default: return taylor_q30(x, 1'b1);
    endcase
  endfunction

  function automatic logic [63:0] mul_ratio(input logic [63:0] t);
    return (t >> 30) * RATIO_Q30 + (((t & 64'h3FFF_FFFF) * RATIO_Q30) >> 30);
  endfunction

  // power thresholds for -72..0 dbfs in 101 steps
  function automatic thr_arr_t build_thr();
    thr_arr_t    t;
    logic [63:0] v;
    t[0]   = '0;
    v      = 64'd1 << 56;
    t[100] = 57'(v);
    for (int i = 99; i >= 1; i--) begin
      v    = mul_ratio(v);
      t[i] = 57'(v);
    end
    return t;
  endfunction

  localparam thr_arr_t LVL_THR = build_thr();

endpackage

### design/mono_fold_meter_spectrum_bands.sv
// mono fold audio path, capture meter and log band spectrum analyzer
// depends on mfmsb_pkg
`timescale 1ns / 1ps

// usage
//   in channel (in_valid/in_ready) takes one beat per item: kind selects an
//   audio frame, a stats read or a spectrum request
//   out channel (out_valid/out_ready) gives one beat per result from a single
//   output register; config is an apb port with enabled, stereo_source and
//   downmix at byte addresses 0, 4 and 8
// latency and throughput
//   frames (while enabled) and stats reads: result in the cycle after the beat,
//   one item per cycle as long as the output register drains
//   spectrum request: windowed load and drain of the ring, then
//   (WINDOW_SIZE/2)*log2(WINDOW_SIZE) butterflies, each read, latch, multiply,
//   write a and write b through the single fft memory and shared multiplier,
//   then per band a setup step, read, latch and square per bin, a binary
//   threshold search and the output step; if disabled, zero band beats only
//   no new item is taken until the sixteenth band beat is out
// reset
//   config goes to disabled, stereo, downmix; meter, clip count, ring pointer
//   and ring fill count clear; unwritten ring slots read as zero via the fill
//   count, so no clearing pass is needed
// stall
//   a stalled out_ready holds the output register and blocks every input
//   item; the spectrum sequencer waits in its output step
module mono_fold_meter_spectrum_bands
  import mfmsb_pkg::*;
#(
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
  parameter int BAND_COUNT  = DEF_BAND_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_in,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_type,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_right,
  output logic [15:0]        peak_level,
  output logic [31:0]        clip_count,
  output logic [3:0]         band_index,
  output logic [6:0]         band_level,
  output logic               last_band
);

  localparam int LG   = $clog2(WINDOW_SIZE);
  localparam int SW   = $clog2(LG);
  localparam int BI   = $clog2(BAND_COUNT);
  localparam int HALF = WINDOW_SIZE / 2;

  typedef logic signed [16:0] tw_arr_t  [HALF];
  typedef logic [14:0]        win_arr_t [WINDOW_SIZE];
  typedef logic [LG-1:0]      k_arr_t   [BAND_COUNT];

  // ---------------------------------------------------------------- roms
  function automatic tw_arr_t build_tw(input logic sin_sel);
    tw_arr_t     t;
    logic [31:0] ph;
    longint      c;
    for (int j = 0; j < HALF; j++) begin
      ph   = 32'(j) << (32 - LG);
      c    = cos_q30(sin_sel ? ph - 32'h4000_0000 : ph);
      t[j] = 17'((c + 64'sd16384) >>> 15);
    end
    return t;
  endfunction

  // hann window, unsigned q0.15
  function automatic win_arr_t build_win();
    win_arr_t    w;
    logic [63:0] num;
    logic [31:0] ph;
    longint      h;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      num = 64'(i) << 32;
      ph  = 32'(num / (WINDOW_SIZE - 1));
      h   = (longint'(FULL_Q30) - cos_q30(ph) + 64'sd32768) >>> 16;
      if (h < 0) h = 0;
      if (h > 32767) h = 32767;
      w[i] = 15'(h);
    end
    return w;
  endfunction

  function automatic int band_edge(input int b);
    int          d;
    logic [63:0] q;
    d = BAND_COUNT - b;
    if (d[0] == 1'b0) q = (64'(HALF) << 16) >> (d >> 1);
    else              q = (64'(HALF) * SQRT2_Q16) >> ((d + 1) >> 1);
    return int'((q + 64'd32768) >> 16);
  endfunction

  function automatic k_arr_t build_k(input logic hi_sel);
    k_arr_t t;
    int     k0;
    int     k1;
    for (int b = 0; b < BAND_COUNT; b++) begin
      k0 = band_edge(b);
      k1 = band_edge(b + 1);
      if (k0 < 1) k0 = 1;
      if (k1 > HALF) k1 = HALF;
      if (k1 < k0) k1 = k0;
      t[b] = LG'(hi_sel ? k1 : k0);
    end
    return t;
  endfunction

  function automatic logic [LG-1:0] bitrev(input logic [LG-1:0] v);
    logic [LG-1:0] r;
    for (int b = 0; b < LG; b++) r[LG-1-b] = v[b];
    return r;
  endfunction

  localparam tw_arr_t  TW_COS  = build_tw(1'b0);
  localparam tw_arr_t  TW_SIN  = build_tw(1'b1);
  localparam win_arr_t WIN_ROM = build_win();
  localparam k_arr_t   K_LO    = build_k(1'b0);
  localparam k_arr_t   K_HI    = build_k(1'b1);

  // ---------------------------------------------------------------- config
  logic cfg_enabled, cfg_stereo, cfg_downmix;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_enabled <= 1'b0;
      cfg_stereo  <= 1'b1;
      cfg_downmix <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[3:2] == REG_ENABLED) cfg_enabled <= pwdata[0];
      if (paddr[3:2] == REG_STEREO)  cfg_stereo  <= pwdata[0];
      if (paddr[3:2] == REG_DOWNMIX) cfg_downmix <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_ENABLED: prdata = {31'd0, cfg_enabled};
      REG_STEREO:  prdata = {31'd0, cfg_stereo};
      REG_DOWNMIX: prdata = {31'd0, cfg_downmix};
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  st_t state, state_next;

  logic                out_free, in_acc, out_load;
  logic [LG-1:0]       ptr;
  logic [LG:0]         fill;
  logic [15:0]         peak;
  logic [31:0]         clips;

  logic [15:0]         ring [WINDOW_SIZE];
  logic signed [15:0]  ring_q;
  logic                ring_we;
  logic [LG-1:0]       ring_ra;

  logic [63:0]         fft_mem [WINDOW_SIZE];
  logic [63:0]         q_a, q_b;
  logic [LG-1:0]       fa, fb, fw_addr;
  logic                fw_en;
  logic [63:0]         fw_data;

  // load pipeline
  logic [LG-1:0]       ld_i, s1_idx, s2_idx;
  logic                s1v, s1_ok, s2v;
  logic [14:0]         win_q;
  logic signed [31:0]  x_q;
  logic signed [15:0]  ld_samp;

  // butterfly
  logic [SW-1:0]       stg;
  logic [LG-2:0]       bf, hl_mask;
  logic [LG-1:0]       a_idx, b_idx;
  logic [LG-2:0]       tw_idx;
  logic [2:0]          mc;
  logic signed [31:0]  ar, ai, br, bi, nb_re, nb_im;
  logic signed [16:0]  c_q, s_q;
  logic signed [31:0]  mul_x, mul_y;
  logic signed [63:0]  prod;
  logic signed [47:0]  acc_r, acc_i;
  logic signed [32:0]  t_r, t_i;
  logic signed [33:0]  sa_r, sa_i, sb_r, sb_i;
  logic                bf_last;

  // band stage
  logic [BI-1:0]       band;
  logic [LG-1:0]       k;
  logic [63:0]         best, pw, pw_sum;
  logic [6:0]          lo, hi, mid;
  logic                sp_zero, band_last;

  // audio datapath
  logic signed [16:0]  lr_sum, m_abs_w;
  logic signed [15:0]  m_val;
  logic [15:0]         m_abs;
  logic                pass_st;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;

  assign pass_st  = cfg_stereo && !cfg_downmix;
  assign lr_sum   = 17'(left_in) + 17'(right_in);
  assign m_val    = cfg_stereo ? lr_sum[16:1] : left_in;
  assign m_abs_w  = (m_val < 0) ? -17'(m_val) : 17'(m_val);
  assign m_abs    = m_abs_w[15:0];
  assign ring_we  = in_acc && (kind == KIND_FRAME) && cfg_enabled && !pass_st;

  // butterfly addressing: a = bf with a zero inserted at bit stg
  assign hl_mask = ~({(LG-1){1'b1}} << stg);
  assign a_idx   = {1'b0, bf} + {1'b0, bf & ~hl_mask};
  assign b_idx   = a_idx | (LG'(1) << stg);
  assign tw_idx  = (bf & hl_mask) << (SW'(LG-1) - stg);
  assign bf_last = (bf == {(LG-1){1'b1}}) && (stg == SW'(LG-1));

  assign t_r  = acc_r[47:15];
  assign t_i  = acc_i[47:15];
  assign sa_r = 34'(ar) + 34'(t_r);
  assign sa_i = 34'(ai) + 34'(t_i);
  assign sb_r = 34'(ar) - 34'(t_r);
  assign sb_i = 34'(ai) - 34'(t_i);

  assign pw_sum    = pw + 64'(prod);
  assign mid       = 7'((8'(lo) + 8'(hi)) >> 1);
  assign band_last = (band == BI'(BAND_COUNT - 1));
  assign ld_samp   = s1_ok ? ring_q : 16'sd0;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && kind == KIND_SPEC) state_next = cfg_enabled ? ST_LOAD : ST_BN_OUT;
      end
      ST_LOAD: begin
        if (ld_i == {LG{1'b1}}) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1v && !s2v) state_next = ST_BF_RD;
      end
      ST_BF_RD:  state_next = ST_BF_LAT;
      ST_BF_LAT: state_next = ST_BF_MUL;
      ST_BF_MUL: begin
        if (mc == 3'd4) state_next = ST_BF_WA;
      end
      ST_BF_WA:  state_next = ST_BF_WB;
      ST_BF_WB:  state_next = bf_last ? ST_BN_INIT : ST_BF_RD;
      ST_BN_INIT: state_next = ST_BN_RD;
      ST_BN_RD:   state_next = ST_BN_LAT;
      ST_BN_LAT:  state_next = ST_BN_SQ;
      ST_BN_SQ: begin
        if (mc == 3'd2) state_next = (k == K_HI[band]) ? ST_BN_SRCH : ST_BN_RD;
      end
      ST_BN_SRCH: begin
        if (hi - lo <= 7'd1) state_next = ST_BN_OUT;
      end
      ST_BN_OUT: begin
        if (out_free) begin
          if (band_last)    state_next = ST_IDLE;
          else if (sp_zero) state_next = ST_BN_OUT;
          else              state_next = ST_BN_INIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memory and mul control
  always_comb begin
    fa      = a_idx;
    fb      = b_idx;
    fw_en   = 1'b0;
    fw_addr = a_idx;
    fw_data = {sa_i[32:1], sa_r[32:1]};
    ring_ra = ptr + ld_i;
    mul_x   = br;
    mul_y   = 32'(c_q);
    if (state == ST_BN_RD) fa = k;
    if (s2v) begin
      fw_en   = 1'b1;
      fw_addr = bitrev(s2_idx);
      fw_data = {32'd0, x_q};
    end else if (state == ST_BF_WA) begin
      fw_en = 1'b1;
    end else if (state == ST_BF_WB) begin
      fw_en   = 1'b1;
      fw_addr = b_idx;
      fw_data = {nb_im, nb_re};
    end
    if (state == ST_BN_SQ) begin
      mul_x = (mc == 3'd0) ? br : bi;
      mul_y = mul_x;
    end else begin
      unique case (mc)
        3'd0:    begin mul_x = br; mul_y = 32'(c_q); end
        3'd1:    begin mul_x = bi; mul_y = 32'(s_q); end
        3'd2:    begin mul_x = bi; mul_y = 32'(c_q); end
        default: begin mul_x = br; mul_y = 32'(s_q); end
      endcase
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (ring_we) ring[ptr] <= m_val;
    ring_q <= ring[ring_ra];
  end

  always_ff @(posedge clk) begin
    if (fw_en) fft_mem[fw_addr] <= fw_data;
    q_a <= fft_mem[fa];
    q_b <= fft_mem[fb];
  end

  // ---------------------------------------------------------------- sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ptr   <= '0;
      fill  <= '0;
      peak  <= '0;
      clips <= '0;
      s1v   <= 1'b0;
      s2v   <= 1'b0;
    end else begin
      state <= state_next;

      // capture meter
      if (ring_we) begin
        ptr <= ptr + 1'b1;
        if (fill != (LG+1)'(WINDOW_SIZE)) fill <= fill + 1'b1;
        if (m_abs > peak) peak <= m_abs;
        if (m_abs >= 16'd32767) clips <= clips + 1'b1;
      end
      if (in_acc && kind == KIND_STATS) begin
        peak  <= '0;
        clips <= '0;
      end

      // windowed load, oldest sample first
      s1v <= (state == ST_LOAD);
      s2v <= s1v;
    end

    win_q  <= WIN_ROM[ld_i];
    s1_idx <= ld_i;
    s1_ok  <= {1'b0, ring_ra} < fill;
    s2_idx <= s1_idx;
    x_q    <= ld_samp * $signed({1'b0, win_q});
    prod   <= mul_x * mul_y;

    unique case (state)
      ST_IDLE: begin
        ld_i    <= '0;
        stg     <= '0;
        bf      <= '0;
        band    <= '0;
        lo      <= '0;
        sp_zero <= !cfg_enabled;
      end
      ST_LOAD: ld_i <= ld_i + 1'b1;
      ST_DRAIN: ;
      ST_BF_RD: ;
      ST_BF_LAT: begin
        ar  <= q_a[31:0];
        ai  <= q_a[63:32];
        br  <= q_b[31:0];
        bi  <= q_b[63:32];
        c_q <= TW_COS[tw_idx];
        s_q <= TW_SIN[tw_idx];
        mc  <= '0;
      end
      ST_BF_MUL: begin
        mc <= mc + 1'b1;
        unique case (mc)
          3'd1:    acc_r <= prod[47:0];
          3'd2:    acc_r <= acc_r + prod[47:0];
          3'd3:    acc_i <= prod[47:0];
          3'd4:    acc_i <= acc_i - prod[47:0];
          default: ;
        endcase
      end
      ST_BF_WA: begin
        nb_re <= sb_r[32:1];
        nb_im <= sb_i[32:1];
      end
      ST_BF_WB: begin
        if (bf == {(LG-1){1'b1}}) stg <= stg + 1'b1;
        bf <= bf + 1'b1;
      end
      ST_BN_INIT: begin
        k    <= K_LO[band];
        best <= '0;
      end
      ST_BN_RD: ;
      ST_BN_LAT: begin
        br <= q_a[31:0];
        bi <= q_a[63:32];
        mc <= '0;
      end
      ST_BN_SQ: begin
        mc <= mc + 1'b1;
        if (mc == 3'd1) pw <= 64'(prod);
        if (mc == 3'd2) begin
          if (pw_sum > best) best <= pw_sum;
          k  <= k + 1'b1;
          lo <= '0;
          hi <= LVL_TOP + 7'd1;
        end
      end
      ST_BN_SRCH: begin
        if (hi - lo > 7'd1) begin
          if (best >= 64'(LVL_THR[mid])) lo <= mid;
          else                           hi <= mid;
        end
      end
      ST_BN_OUT: begin
        if (out_free) band <= band + 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_load = 1'b0;
    if (in_acc) begin
      if (kind == KIND_FRAME) out_load = cfg_enabled;
      if (kind == KIND_STATS) out_load = 1'b1;
    end
    if (state == ST_BN_OUT && out_free) out_load = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end

    if (out_load) begin
      result_type <= RES_FRAME;
      out_left    <= '0;
      out_right   <= '0;
      peak_level  <= '0;
      clip_count  <= '0;
      band_index  <= '0;
      band_level  <= '0;
      last_band   <= 1'b0;
      if (state == ST_BN_OUT) begin
        result_type <= RES_BAND;
        band_index  <= 4'(band);
        band_level  <= sp_zero ? 7'd0 : lo;
        last_band   <= band_last;
      end else if (kind == KIND_STATS) begin
        result_type <= RES_STATS;
        peak_level  <= peak;
        clip_count  <= clips;
      end else if (pass_st) begin
        out_left  <= left_in;
        out_right <= right_in;
      end else begin
        out_left  <= m_val;
        out_right <= m_val;
      end
    end
  end

endmodule

### bench/testbench.sv
// self-checking bench for mono_fold_meter_spectrum_bands: a scoreboard class
// predicts frames, meter reads and band levels; depends on mfmsb_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import mfmsb_pkg::*;

  localparam int          NPTS       = 512;
  localparam int          LG         = 9;
  localparam int          NBANDS     = 16;
  localparam logic [1:0]  KIND_SPARE = 2'd3;
  localparam longint      CYCLE_CAP  = 40000000;
  localparam int          LONG_HOLD  = 300;
  localparam int          SETTLE     = 40;

  typedef struct packed {
    logic [1:0]         rtype;
    logic signed [15:0] lft;
    logic signed [15:0] rgt;
    logic [15:0]        pk;
    logic [31:0]        cc;
    logic [3:0]         bidx;
    logic [6:0]         lvl;
    logic               lastb;
  } beat_t;

  // scoreboard: own copy of the registers, ring, meter and fft state
  class meter_scoreboard;
    bit                 en, stereo, dmix;
    logic signed [15:0] ring [NPTS];
    int                 wptr;
    int                 peak;
    logic [31:0]        clips;
    longint             fre [NPTS];
    longint             fim [NPTS];
    longint             twc [NPTS/2];
    longint             tws [NPTS/2];
    longint             hann [NPTS];
    logic [63:0]        thr [101];
    beat_t              pending_beats [$];
    int                 errors;
    int                 checked;

    function new();
      logic [63:0] v;
      logic [31:0] ph;
      longint      h;
      en = 0; stereo = 1; dmix = 1;
      foreach (ring[i]) ring[i] = '0;
      wptr = 0; peak = 0; clips = '0; errors = 0; checked = 0;
      for (int j = 0; j < NPTS/2; j++) begin
        ph = 32'(64'(j) << (32 - LG));
        twc[j] = (cos_q30(ph) + 16384) >>> 15;
        tws[j] = (cos_q30(ph - 32'h4000_0000) + 16384) >>> 15;
      end
      for (int i = 0; i < NPTS; i++) begin
        ph = 32'((64'(i) << 32) / 64'(NPTS - 1));
        h = ((longint'(1) <<< 30) - cos_q30(ph) + 32768) >>> 16;
        if (h < 0) h = 0;
        if (h > 32767) h = 32767;
        hann[i] = h;
      end
      thr[0] = '0;
      thr[100] = 64'd1 << 56;
      for (int k = 99; k >= 1; k--) begin
        v = thr[k+1];
        thr[k] = (v >> 30) * 64'd909703494 + (((v & 64'h3FFF_FFFF) * 64'd909703494) >> 30);
      end
    endfunction

    // truncated power series of cos (even) or sin (odd), q30
    function longint series_q30(logic [63:0] x, bit odd);
      logic [63:0] x2, term;
      longint      acc;
      int          n;
      x2 = (x * x) >> 30;
      term = odd ? x : (64'd1 << 30);
      acc = longint'(term);
      n = odd;
      for (int it = 1; it <= 9; it++) begin
        term = ((term * x2) >> 30) / 64'((n + 1) * (n + 2));
        n += 2;
        if (it % 2) acc -= longint'(term);
        else        acc += longint'(term);
      end
      return acc;
    endfunction

    function longint cos_q30(logic [31:0] ph);
      logic [63:0] x;
      x = ({32'd0, ph & 32'h3FFF_FFFF} * 64'd1686629713) >> 30;
      case (ph[31:30])
        2'd0:    return series_q30(x, 0);
        2'd1:    return -series_q30(x, 1);
        2'd2:    return -series_q30(x, 0);
        default: return series_q30(x, 1);
      endcase
    endfunction

    function void set_reg(logic [1:0] idx, bit val);
      case (idx)
        REG_ENABLED: en = val;
        REG_STEREO:  stereo = val;
        REG_DOWNMIX: dmix = val;
        default: ;
      endcase
    endfunction

    function void run_fft();
      longint  t, tr, ti, ar, ai;
      int      j, hl, stp, a, b;
      for (int i = 0; i < NPTS; i++) begin
        fre[i] = longint'(ring[(wptr + i) % NPTS]) * hann[i];
        fim[i] = 0;
      end
      for (int i = 0; i < NPTS; i++) begin
        j = 0;
        for (int k = 0; k < LG; k++) j |= ((i >> k) & 1) << (LG - 1 - k);
        if (i < j) begin
          t = fre[i]; fre[i] = fre[j]; fre[j] = t;
          t = fim[i]; fim[i] = fim[j]; fim[j] = t;
        end
      end
      for (int len = 2; len <= NPTS; len *= 2) begin
        hl = len / 2;
        stp = NPTS / len;
        for (int base = 0; base < NPTS; base += len) begin
          for (int k = 0; k < hl; k++) begin
            a = base + k;
            b = a + hl;
            tr = (fre[b] * twc[k*stp] + fim[b] * tws[k*stp]) >>> 15;
            ti = (fim[b] * twc[k*stp] - fre[b] * tws[k*stp]) >>> 15;
            ar = fre[a];
            ai = fim[a];
            fre[a] = (ar + tr) >>> 1;
            fim[a] = (ai + ti) >>> 1;
            fre[b] = (ar - tr) >>> 1;
            fim[b] = (ai - ti) >>> 1;
          end
        end
      end
    endfunction

    function int edge_bin(int b);
      int          d;
      logic [63:0] q;
      d = NBANDS - b;
      if (d % 2 == 0) q = (64'(NPTS/2) << 16) >> (d / 2);
      else            q = (64'(NPTS/2) * 64'd92682) >> ((d + 1) / 2);
      return int'((q + 64'd32768) >> 16);
    endfunction

    function logic [6:0] band_power_level(int b);
      int          k0, k1;
      logic [63:0] best, ar, am, p;
      logic [6:0]  lv;
      k0 = edge_bin(b);
      k1 = edge_bin(b + 1);
      best = '0;
      lv = '0;
      if (k0 < 1) k0 = 1;
      if (k1 > NPTS/2) k1 = NPTS/2;
      if (k1 < k0) k1 = k0;
      for (int k = k0; k <= k1; k++) begin
        ar = 64'(fre[k] < 0 ? -fre[k] : fre[k]);
        am = 64'(fim[k] < 0 ? -fim[k] : fim[k]);
        p = ar * ar + am * am;
        if (p > best) best = p;
      end
      for (int v = 1; v <= 100; v++) if (best >= thr[v]) lv = 7'(v);
      return lv;
    endfunction

    // accepted input beat: advance state, queue what it should produce
    function void note_input(logic [1:0] k, logic signed [15:0] l, logic signed [15:0] r);
      beat_t e;
      int    m, mag;
      e = '0;
      case (k)
        KIND_FRAME: begin
          if (en) begin
            if (stereo && !dmix) begin
              e.lft = l;
              e.rgt = r;
            end else begin
              m = stereo ? ((int'(l) + int'(r)) >>> 1) : int'(l);
              mag = m < 0 ? -m : m;
              ring[wptr] = 16'(m);
              wptr = (wptr + 1) % NPTS;
              if (mag > peak) peak = mag;
              if (mag >= 32767) clips++;
              e.lft = 16'(m);
              e.rgt = 16'(m);
            end
            e.rtype = RES_FRAME;
            pending_beats.push_back(e);
          end
        end
        KIND_STATS: begin
          e.rtype = RES_STATS;
          e.pk = 16'(peak);
          e.cc = clips;
          peak = 0;
          clips = '0;
          pending_beats.push_back(e);
        end
        KIND_SPEC: begin
          if (en) run_fft();
          for (int b = 0; b < NBANDS; b++) begin
            e = '0;
            e.rtype = RES_BAND;
            e.bidx = 4'(b);
            e.lvl = en ? band_power_level(b) : 7'd0;
            e.lastb = (b == NBANDS - 1);
            pending_beats.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(beat_t got);
      beat_t w;
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
        return;
      end
      w = pending_beats.pop_front();
      checked++;
      if (got.rtype !== w.rtype)
        $display("%0t: result_type exp %0d got %0d", $time, w.rtype, got.rtype);
      if (got.lft !== w.lft)
        $display("%0t: out_left exp %0d got %0d", $time, w.lft, got.lft);
      if (got.rgt !== w.rgt)
        $display("%0t: out_right exp %0d got %0d", $time, w.rgt, got.rgt);
      if (got.pk !== w.pk)
        $display("%0t: peak_level exp %0d got %0d", $time, w.pk, got.pk);
      if (got.cc !== w.cc)
        $display("%0t: clip_count exp %0d got %0d", $time, w.cc, got.cc);
      if (got.bidx !== w.bidx)
        $display("%0t: band_index exp %0d got %0d", $time, w.bidx, got.bidx);
      if (got.lvl !== w.lvl)
        $display("%0t: band_level exp %0d got %0d", $time, w.lvl, got.lvl);
      if (got.lastb !== w.lastb)
        $display("%0t: last_band exp %0d got %0d", $time, w.lastb, got.lastb);
      if (got !== w) errors++;
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid, in_ready;
  logic [1:0]         kind;
  logic signed [15:0] left_in, right_in;
  logic               out_valid, out_ready;
  logic [1:0]         result_type;
  logic signed [15:0] out_left, out_right;
  logic [15:0]        peak_level;
  logic [31:0]        clip_count;
  logic [3:0]         band_index;
  logic [6:0]         band_level;
  logic               last_band;

  meter_scoreboard sb;
  longint          cycles;
  bit              idle_on;     // random gaps on both sides
  bit              hold_req;    // one long receiver hold-off
  int              n_frames, n_stats, n_spec, n_spare;

  mono_fold_meter_spectrum_bands DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_ready(out_ready), .result_type(result_type),
    .out_left(out_left), .out_right(out_right), .peak_level(peak_level),
    .clip_count(clip_count), .band_index(band_index), .band_level(band_level),
    .last_band(last_band)
  );

  always #6 clk = ~clk;

  // run limit; the bench stops with a failure once the cycle count passes
  // CYCLE_CAP
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // handshakes are sampled mid-cycle, where every driven and registered
  // signal has settled; a beat seen here completes at the next rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(kind, left_in, right_in);
      if (out_valid && out_ready)
        sb.check_result('{result_type, out_left, out_right, peak_level,
                          clip_count, band_index, band_level, last_band});
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request so the
  // output register stays full and backs up the input side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one input beat; valid stays up until ready is seen
  task automatic send_beat(logic [1:0] k, logic signed [15:0] l, logic signed [15:0] r);
    bit took;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    left_in  <= l;
    right_in <= r;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    case (k)
      KIND_FRAME: n_frames++;
      KIND_STATS: n_stats++;
      KIND_SPEC:  n_spec++;
      default:    n_spare++;
    endcase
  endtask

  // setup then access phase; register written at the access edge
  task automatic apb_write(logic [1:0] idx, bit val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // sender pause: hold off until every queued result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(bit e, bit s, bit d);
    wait_drain();
    apb_write(REG_ENABLED, e);
    apb_write(REG_STEREO, s);
    apb_write(REG_DOWNMIX, d);
  endtask

  // random sample, with random amplitude so band levels spread out
  function automatic logic signed [15:0] rand_sample();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> $urandom_range(0, 12);
  endfunction

  task automatic rand_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 86)      send_beat(KIND_FRAME, rand_sample(), rand_sample());
    else if (pick < 93) send_beat(KIND_STATS, rand_sample(), rand_sample());
    else if (pick < 96) send_beat(KIND_SPEC, rand_sample(), rand_sample());
    else                send_beat(KIND_SPARE, rand_sample(), rand_sample());
  endtask

  initial begin
    clk = 1'b0; rst = 1'b1; cycles = 0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; kind = KIND_FRAME; left_in = '0; right_in = '0;
    idle_on = 1'b1; hold_req = 1'b0;
    n_frames = 0; n_stats = 0; n_spec = 0; n_spare = 0;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset mode is disabled: frames vanish, spectrum gives zero levels
    send_beat(KIND_FRAME, 16'sd1234, -16'sd5);
    send_beat(KIND_STATS, '0, '0);
    send_beat(KIND_SPEC, '0, '0);
    send_beat(KIND_SPARE, 16'sd7, 16'sd7);

    // stereo fold: full scale both ways, floor on odd negative sums
    set_mode(1, 1, 1);
    send_beat(KIND_SPEC, '0, '0);            // ring still all zeros
    send_beat(KIND_FRAME, 16'sd32767, 16'sd32767);
    send_beat(KIND_FRAME, -16'sd32768, -16'sd32768);
    send_beat(KIND_FRAME, -16'sd1, 16'sd0);
    send_beat(KIND_FRAME, 16'sd32767, -16'sd32768);
    send_beat(KIND_FRAME, 16'sd32767, 16'sd32766);
    send_beat(KIND_STATS, '0, '0);
    send_beat(KIND_STATS, '0, '0);           // cleared by the previous read
    send_beat(KIND_SPEC, '0, '0);

    // stereo passthrough: nothing captured
    set_mode(1, 1, 0);
    send_beat(KIND_FRAME, -16'sd32768, 16'sd32767);
    send_beat(KIND_FRAME, 16'sd32767, -16'sd32768);
    send_beat(KIND_STATS, '0, '0);

    // mono source: downmix ignored, right channel ignored
    set_mode(1, 0, 0);
    send_beat(KIND_FRAME, -16'sd32768, 16'sd99);
    send_beat(KIND_FRAME, 16'sd32767, -16'sd1);
    send_beat(KIND_FRAME, -16'sd32767, 16'sd0);
    send_beat(KIND_STATS, '0, '0);
    send_beat(KIND_SPEC, '0, '0);

    // random phases over several register settings; the first one holds
    // the receiver off while random beats keep coming
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_mode(1, 1, 1);
        1: set_mode(1, 0, 1);
        2: set_mode(1, 1, 0);
        3: set_mode(0, 1, 1);
        4: set_mode(1, 0, 0);
        5: set_mode(0, 0, 0);
        default: set_mode(1, 1, 1);
      endcase
      if (ph == 0) hold_req = 1'b1;
      repeat (40) rand_beat();
    end

    // last stretch at full rate, no gaps on either side
    set_mode(1, 1, 1);
    idle_on = 1'b0;
    repeat (75) rand_beat();
    send_beat(KIND_SPEC, '0, '0);
    send_beat(KIND_STATS, '0, '0);
    wait_drain();

    $display("covered %0d frames, %0d meter reads, %0d spectrum requests, %0d ignored kinds",
             n_frames, n_stats, n_spec, n_spare);
    $display("%0d result beats compared, %0d bad", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/mfmsb_pkg.sv
design/mono_fold_meter_spectrum_bands.sv
bench/testbench.sv
